// ===== design/hbp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hbp_pkg;

  localparam int SYMBOL_COUNT_DEF = 256;
  localparam int MAX_CODE_LEN_DEF = 32;

  localparam int SYMBOL_W    = 8;
  localparam int CODE_BITS_W = 32;
  localparam int CODE_LEN_W  = 6;
  localparam int FUNC_W      = 2;
  localparam int BYTE_W      = 8;
  localparam int BYTE_SH     = 3;
  localparam int PEND_W      = 7;
  localparam int COUNT_W     = 4;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 16;

  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(BYTE_W);

  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD   = 2'd0,
    FN_ENCODE = 2'd1,
    FN_FLUSH  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MERGE,
    ST_EMIT,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic merge;
    logic shift;
    logic clear;
  } acc_ctrl_t;

  typedef struct packed {
    logic                byte_ready;
    logic                last_byte;
    logic [BYTE_SH-1:0]  pend_count;
  } acc_stat_t;

endpackage

`default_nettype wire

// ===== design/huffman_encoder_bit_packer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Huffman encoder with a loadable code table and an lsb-first byte packer. A load word
// (func 0) writes one symbol's code, first code bit in bit 0, and its length, saturated to
// the smaller of MAX_CODE_LEN and 32, into a SYMBOL_COUNT-entry table. An encode word
// (func 1) reads the table, merges the code above the up to seven pending bits and then
// emits one full byte per cycle while the output is free through a shift-by-eight unit,
// up to 4 bytes in all. A flush word (func 2) emits the zero-padded partial byte and
// its bit count (0 if nothing is pending) with tlast. The block takes one word at a time;
// a held output word only delays the next byte. Encoding a symbol that was never loaded
// gives an unspecified code; load and encode words for symbols at or above SYMBOL_COUNT
// and func 3 words are dropped with no output.
module huffman_encoder_bit_packer
  import hbp_pkg::*;
#(
  parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // symbol [7:0], code_bits [39:8], code_length [45:40], zero [47:46]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // func [1:0]
  input  wire logic [FUNC_W-1:0]      in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // packed_byte [7:0], bit_count [11:8], zero [15:12]
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  output logic                        out_tlast
);

  localparam int LEN_LIM   = (MAX_CODE_LEN < CODE_BITS_W) ? MAX_CODE_LEN : CODE_BITS_W;
  localparam int CL_W      = $clog2(LEN_LIM + 1);
  localparam int SYM_IDX_W = $clog2(SYMBOL_COUNT);
  localparam int ENTRY_W   = CL_W + LEN_LIM;

  logic [SYMBOL_W-1:0]    in_symbol;
  logic [CODE_BITS_W-1:0] in_code_bits;
  logic [CODE_LEN_W-1:0]  in_code_length;
  func_t                  in_func;
  logic                   sym_ok;

  assign in_symbol      = in_tdata[SYMBOL_W-1:0];
  assign in_code_bits   = in_tdata[SYMBOL_W+CODE_BITS_W-1:SYMBOL_W];
  assign in_code_length = in_tdata[SYMBOL_W+CODE_BITS_W+CODE_LEN_W-1:SYMBOL_W+CODE_BITS_W];
  assign in_func        = func_t'(in_tuser);
  assign sym_ok         = ({1'b0, in_symbol} < (SYMBOL_W + 1)'(SYMBOL_COUNT));

  // saturate the length and drop stray bits before they reach the table
  logic [CODE_LEN_W-1:0] len_sat;
  logic [CL_W-1:0]       wr_len;
  logic [LEN_LIM-1:0]    wr_code;

  assign len_sat = (in_code_length > CODE_LEN_W'(LEN_LIM)) ? CODE_LEN_W'(LEN_LIM)
                                                            : in_code_length;
  assign wr_len  = CL_W'(len_sat);
  assign wr_code = in_code_bits[LEN_LIM-1:0] & ~({LEN_LIM{1'b1}} << len_sat);

  logic                 tbl_wr_en;
  logic                 tbl_rd_en;
  logic [ENTRY_W-1:0]   tbl_rd_data;

  hbp_code_table #(
    .DEPTH  (SYMBOL_COUNT),
    .IDX_W  (SYM_IDX_W),
    .DATA_W (ENTRY_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (in_symbol[SYM_IDX_W-1:0]),
    .wr_data ({wr_len, wr_code}),
    .rd_en   (tbl_rd_en),
    .rd_addr (in_symbol[SYM_IDX_W-1:0]),
    .rd_data (tbl_rd_data)
  );

  acc_ctrl_t          acc_ctrl;
  acc_stat_t          acc_stat;
  logic [BYTE_W-1:0]  acc_byte;

  hbp_bit_acc #(
    .CODE_W (LEN_LIM),
    .CL_W   (CL_W)
  ) u_acc (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (acc_ctrl),
    .code     (tbl_rd_data[LEN_LIM-1:0]),
    .clen     (tbl_rd_data[ENTRY_W-1:LEN_LIM]),
    .stat     (acc_stat),
    .acc_byte (acc_byte)
  );

  state_t state_r, state_nxt;

  logic               out_valid_r;
  logic [BYTE_W-1:0]  out_byte_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_last_r;
  logic               out_load;
  logic [COUNT_W-1:0] load_count;
  logic               load_last;
  logic               out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt  = state_r;
    in_tready  = (state_r == ST_IDLE);
    acc_ctrl   = '0;
    tbl_wr_en  = 1'b0;
    tbl_rd_en  = 1'b0;
    out_load   = 1'b0;
    load_count = FULL_COUNT;
    load_last  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          unique case (in_func)
            FN_LOAD: begin
              tbl_wr_en = sym_ok;
            end
            FN_ENCODE: begin
              if (sym_ok) begin
                tbl_rd_en = 1'b1;
                state_nxt = ST_MERGE;
              end
            end
            FN_FLUSH: begin
              state_nxt = ST_FLUSH;
            end
            default: begin
            end
          endcase
        end
      end
      ST_MERGE: begin
        acc_ctrl.merge = 1'b1;
        state_nxt      = ST_EMIT;
      end
      ST_EMIT: begin
        if (!acc_stat.byte_ready) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          acc_ctrl.shift = 1'b1;
          out_load       = 1'b1;
          load_last      = acc_stat.last_byte;
          if (acc_stat.last_byte) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          acc_ctrl.clear = 1'b1;
          out_load       = 1'b1;
          load_count     = COUNT_W'(acc_stat.pend_count);
          load_last      = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte_r  <= acc_byte;
      out_count_r <= load_count;
      out_last_r  <= load_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_count_r, out_byte_r});
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  // nothing complete may sit in the accumulator while new words are taken
  a_idle_no_full_byte: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !acc_stat.byte_ready)
    else $error("full byte left pending while idle");

  // an encode of a valid symbol holds off the input for at least the merge cycle
  a_encode_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_func == FN_ENCODE && sym_ok |=> !in_tready)
    else $error("input taken during encode");

  // partial bytes only come from a flush, which always ends its run
  a_partial_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_count_r != FULL_COUNT |-> out_tlast)
    else $error("partial byte without tlast");

  // a flush empties the pending bits
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FLUSH && out_free |=> acc_stat.pend_count == '0)
    else $error("pending bits survive a flush");
`endif

endmodule

`default_nettype wire

// ===== design/hbp_code_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hbp_code_table
  import hbp_pkg::*;
#(
  parameter int DEPTH  = SYMBOL_COUNT_DEF,
  parameter int IDX_W  = 8,
  parameter int DATA_W = 38
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [IDX_W-1:0]  wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [IDX_W-1:0]  rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/hbp_bit_acc.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hbp_bit_acc
  import hbp_pkg::*;
#(
  parameter int CODE_W = CODE_BITS_W,
  parameter int CL_W   = CODE_LEN_W
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire acc_ctrl_t         ctrl,
  input  wire logic [CODE_W-1:0] code,
  input  wire logic [CL_W-1:0]   clen,
  output acc_stat_t              stat,
  output logic      [BYTE_W-1:0] acc_byte
);

  localparam int ACC_W = PEND_W + CODE_W;
  localparam int TOT_W = $clog2(ACC_W + 1);

  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [TOT_W-1:0] total_r, total_nxt;
  logic [TOT_W-1:0] remain;

  // bits above total are always zero, so the low byte is already padded
  always_comb begin
    acc_nxt   = acc_r;
    total_nxt = total_r;
    if (ctrl.clear) begin
      acc_nxt   = '0;
      total_nxt = '0;
    end else if (ctrl.merge) begin
      acc_nxt   = ACC_W'(acc_r[PEND_W-1:0]) | (ACC_W'(code) << total_r[BYTE_SH-1:0]);
      total_nxt = total_r + TOT_W'(clen);
    end else if (ctrl.shift) begin
      acc_nxt   = acc_r >> BYTE_W;
      total_nxt = remain;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      total_r <= '0;
    end else begin
      acc_r   <= acc_nxt;
      total_r <= total_nxt;
    end
  end

  assign remain          = total_r - TOT_W'(BYTE_W);
  assign stat.byte_ready = |total_r[TOT_W-1:BYTE_SH];
  assign stat.last_byte  = ~|remain[TOT_W-1:BYTE_SH];
  assign stat.pend_count = total_r[BYTE_SH-1:0];
  assign acc_byte        = acc_r[BYTE_W-1:0];

endmodule

`default_nettype wire
